// ===== rtl/core/worley_noise_f1_3d_unit_assert.svh =====
// Assertion macros shared by the Worley F1 noise unit.
`ifndef WORLEY_NOISE_F1_3D_UNIT_ASSERT_SVH
`define WORLEY_NOISE_F1_3D_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, disabled while rst_n is low
`define WNF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WNF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wnf_pkg.sv =====
// Constants and types shared by the Worley F1 noise unit.
`default_nettype none
package wnf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int OUT_W         = 17;
    localparam int VAL_W         = 2 * OUT_W;

    localparam logic [31:0] HASH_KX = 32'h27d4eb2d;
    localparam logic [31:0] HASH_KY = 32'h85ebca6b;
    localparam logic [31:0] HASH_KZ = 32'hc2b2ae35;
    localparam logic [31:0] MIX_1   = 32'h2c1b3c6d;
    localparam logic [31:0] MIX_2   = 32'h297a2d39;

    // index 0 is the plain hash, 1 and 2 the perturbed ones
    localparam logic [31:0] MASK_X [3] = '{32'h00000000, 32'h68bc21eb, 32'hdeadbeef};
    localparam logic [31:0] MASK_Y [3] = '{32'h00000000, 32'h02e5be93, 32'h12345678};
    localparam logic [31:0] MASK_Z [3] = '{32'h00000000, 32'h9e3779b9, 32'habcdef01};

    typedef struct packed {
        logic adv;
        logic vld;
    } ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/wnf_cell.sv =====
// One neighbour cell: three hashes, feature offset and squared distance.
`default_nettype none
module wnf_cell #(
    parameter int FRAC_BITS = wnf_pkg::FRAC_BITS_DEF,
    parameter int OX        = 0,
    parameter int OY        = 0,
    parameter int OZ        = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire wnf_pkg::ctl_t              ctl,
    input  wire logic [31:0]                seed,
    input  wire logic [31:0]                px [3],
    input  wire logic [31:0]                py [3],
    input  wire logic [31:0]                pz [3],
    input  wire logic [FRAC_BITS-1:0]       frac_in [3],
    output logic [2*FRAC_BITS+3:0]          d2,
    output logic                            d2_vld
);
    localparam int DW  = FRAC_BITS + 2;
    localparam int D2W = 2 * FRAC_BITS + 4;
    localparam logic signed [DW-1:0] OFF [3] = '{
        DW'(OX * (1 << FRAC_BITS)), DW'(OY * (1 << FRAC_BITS)), DW'(OZ * (1 << FRAC_BITS))};

    logic [31:0]             m1_reg [3];
    logic [31:0]             m2_reg [3];
    logic [FRAC_BITS-1:0]    fc_reg [3];
    logic [FRAC_BITS-1:0]    fd_reg [3];
    logic signed [DW-1:0]    d_reg  [3];
    logic [D2W-1:0]          d2_reg;
    logic                    vc_reg, vd_reg, ve_reg, vf_reg;

    logic [31:0]             h0 [3];
    logic [31:0]             h1 [3];
    logic [31:0]             g  [3];
    logic [31:0]             h2 [3];
    logic signed [D2W-1:0]   sq [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h0[k] = seed ^ px[k] ^ py[k] ^ pz[k];
            h1[k] = h0[k] ^ (h0[k] >> 15);
            g[k]  = m1_reg[k] ^ (m1_reg[k] >> 12);
            h2[k] = m2_reg[k] ^ (m2_reg[k] >> 15);
            sq[k] = d_reg[k] * d_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            vc_reg <= ctl.vld;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m1_reg[k] <= 32'(h1[k] * wnf_pkg::MIX_1);
                fc_reg[k] <= frac_in[k];
                m2_reg[k] <= 32'(g[k] * wnf_pkg::MIX_2);
                fd_reg[k] <= fc_reg[k];
                // offset + hash fraction - sample fraction, never wraps
                d_reg[k]  <= OFF[k] + $signed({2'b00, h2[k][31 -: FRAC_BITS]})
                             - $signed({2'b00, fd_reg[k]});
            end
            d2_reg <= $unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]);
        end
    end

    assign d2     = d2_reg;
    assign d2_vld = vf_reg;
endmodule
`default_nettype wire

// ===== rtl/core/wnf_min_tree.sv =====
// Registered minimum over the 27 squared distances, three stages.
`default_nettype none
module wnf_min_tree #(
    parameter int FRAC_BITS = wnf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire wnf_pkg::ctl_t              ctl,
    input  wire logic [2*FRAC_BITS+3:0]     d2 [27],
    output logic [2*FRAC_BITS+3:0]          best,
    output logic                            best_vld
);
    localparam int D2W = 2 * FRAC_BITS + 4;

    logic [D2W-1:0] m1_reg [9];
    logic [D2W-1:0] m2_reg [3];
    logic [D2W-1:0] m3_reg;
    logic           v1_reg, v2_reg, v3_reg;

    function automatic logic [D2W-1:0] min3(input logic [D2W-1:0] a, input logic [D2W-1:0] b,
                                            input logic [D2W-1:0] c);
        logic [D2W-1:0] ab;
        ab = (a < b) ? a : b;
        return (ab < c) ? ab : c;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctl.adv)
        begin
            v1_reg <= ctl.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int i = 0; i < 9; i++)
                m1_reg[i] <= min3(d2[3*i], d2[3*i+1], d2[3*i+2]);
            for (int i = 0; i < 3; i++)
                m2_reg[i] <= min3(m1_reg[3*i], m1_reg[3*i+1], m1_reg[3*i+2]);
            m3_reg <= min3(m2_reg[0], m2_reg[1], m2_reg[2]);
        end
    end

    assign best     = m3_reg;
    assign best_vld = v3_reg;
endmodule
`default_nettype wire

// ===== rtl/core/wnf_isqrt.sv =====
// Pipelined restoring square root, one result bit per stage, with saturation.
`default_nettype none
`include "worley_noise_f1_3d_unit_assert.svh"
module wnf_isqrt #(
    parameter int FRAC_BITS = wnf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire wnf_pkg::ctl_t                  ctl,
    input  wire logic [2*FRAC_BITS+3:0]         best,
    output logic [wnf_pkg::OUT_W-1:0]           root,
    output logic                                root_vld
);
    localparam int OW   = wnf_pkg::OUT_W;
    localparam int VW   = wnf_pkg::VAL_W;
    localparam int TW   = VW + 1;
    localparam int D2W  = 2 * FRAC_BITS + 4;
    localparam int SH_R = (FRAC_BITS >= 16) ? 2 * FRAC_BITS - 32 : 0;
    localparam int SH_L = (FRAC_BITS < 16) ? 32 - 2 * FRAC_BITS : 0;
    localparam int AW   = D2W + SH_L;

    logic [AW-1:0] aligned;
    logic          sat;
    logic [VW-1:0] val;

    // scale to 32 fraction bits; all ones gives the saturated root
    assign aligned = (AW'(best) << SH_L) >> SH_R;
    assign sat     = |aligned[AW-1:VW];
    assign val     = sat ? {VW{1'b1}} : aligned[VW-1:0];

    logic [OW-1:0] root_w [OW+1];
    logic [VW-1:0] rem_w  [OW+1];
    logic [OW-1:0] root_reg [OW];
    logic [VW-1:0] rem_reg  [OW];
    logic          vld_reg  [OW];

    assign root_w[0] = '0;
    assign rem_w[0]  = val;

    for (genvar i = 0; i < OW; i++)
    begin : g_stage
        localparam int B = OW - 1 - i;
        logic [TW-1:0] trial;
        logic          take;

        assign trial = (TW'(root_w[i]) << (B + 1)) + (TW'(1) << (2 * B));
        assign take  = {1'b0, rem_w[i]} >= trial;

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                root_reg[i] <= take ? (root_w[i] | (OW'(1) << B)) : root_w[i];
                rem_reg[i]  <= take ? VW'({1'b0, rem_w[i]} - trial) : rem_w[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (ctl.adv)
                vld_reg[i] <= (i == 0) ? ctl.vld : vld_reg[(i == 0) ? 0 : i - 1];
        end

        assign root_w[i+1] = root_reg[i];
        assign rem_w[i+1]  = rem_reg[i];
    end

    assign root     = root_w[OW];
    assign root_vld = vld_reg[OW-1];

    // remainder of a finished root never exceeds twice the root
    `WNF_ASSERT_IMP(a_rem_bound, vld_reg[OW-1],
        rem_w[OW] <= {{(VW-OW-1){1'b0}}, root_w[OW], 1'b0}, "square root remainder too large")
endmodule
`default_nettype wire

// ===== rtl/core/worley_noise_f1_3d_unit.sv =====
// Top level of the 3D Worley F1 noise unit.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tdata: pos_x, pos_y, pos_z
//  m_*       out  m_tvalid / m_tready    m_tdata: nearest_distance
//  cfg_*     in   cfg_valid / cfg_ready  cfg_data: noise_seed
//
// One beat in and one beat out per cycle while the output is not stalled. A beat passes
// through the cell indexing and index product registers, the hashing and distance registers
// of each cell, the min tree, 17 pipelined square root stages and the output register.
// The whole pipeline stalls while the output holds a beat that is not taken.
// rst_n clears the valid bits and sets noise_seed to zero.
`default_nettype none
`include "worley_noise_f1_3d_unit_assert.svh"
module worley_noise_f1_3d_unit #(
    parameter int FRAC_BITS = wnf_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // nearest_distance[16:0], zero fill
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data   // noise_seed
);
    localparam int D2W = 2 * FRAC_BITS + 4;
    localparam int OW  = wnf_pkg::OUT_W;

    logic [31:0] seed_reg;
    logic        adv;
    logic        out_valid_reg;
    logic [OW-1:0] out_dist_reg;

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_valid)
            seed_reg <= cfg_data;
    end

    // stage A: cell indices of the neighbourhood and sample fractions
    logic [31:0]          cx_reg [3][3];   // [axis][offset]
    logic [FRAC_BITS-1:0] fa_reg [3];
    logic [FRAC_BITS-1:0] fb_reg [3];
    logic                 va_reg, vb_reg;
    logic [31:0]          prod_x_reg [3][3];   // [offset][variant]
    logic [31:0]          prod_y_reg [3][3];
    logic [31:0]          prod_z_reg [3][3];

    logic [31:0] pos      [3];
    logic [31:0] cell_idx [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pos[a]      = s_tdata[32*a +: 32];
            cell_idx[a] = 32'($signed(pos[a]) >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int o = 0; o < 3; o++)
                    cx_reg[a][o] <= cell_idx[a] + 32'(o - 1);
                fa_reg[a] <= pos[a][FRAC_BITS-1:0];
                fb_reg[a] <= fa_reg[a];
            end
            for (int o = 0; o < 3; o++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_x_reg[o][k] <= 32'((cx_reg[0][o] ^ wnf_pkg::MASK_X[k])
                                            * wnf_pkg::HASH_KX);
                    prod_y_reg[o][k] <= 32'((cx_reg[1][o] ^ wnf_pkg::MASK_Y[k])
                                            * wnf_pkg::HASH_KY);
                    prod_z_reg[o][k] <= 32'((cx_reg[2][o] ^ wnf_pkg::MASK_Z[k])
                                            * wnf_pkg::HASH_KZ);
                end
            end
        end
    end

    wnf_pkg::ctl_t  cell_ctl;
    logic [D2W-1:0] d2_w [27];
    logic           cell_vld [27];

    assign cell_ctl = '{adv: adv, vld: vb_reg};

    for (genvar gz = 0; gz < 3; gz++)
    begin : g_z
        for (genvar gy = 0; gy < 3; gy++)
        begin : g_y
            for (genvar gx = 0; gx < 3; gx++)
            begin : g_x
                wnf_cell #(
                    .FRAC_BITS (FRAC_BITS),
                    .OX        (gx - 1),
                    .OY        (gy - 1),
                    .OZ        (gz - 1)
                ) u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .ctl     (cell_ctl),
                    .seed    (seed_reg),
                    .px      (prod_x_reg[gx]),
                    .py      (prod_y_reg[gy]),
                    .pz      (prod_z_reg[gz]),
                    .frac_in (fb_reg),
                    .d2      (d2_w[gz*9 + gy*3 + gx]),
                    .d2_vld  (cell_vld[gz*9 + gy*3 + gx])
                );
            end
        end
    end

    wnf_pkg::ctl_t  min_ctl;
    logic [D2W-1:0] best;
    logic           best_vld;

    assign min_ctl = '{adv: adv, vld: cell_vld[0]};

    wnf_min_tree #(
        .FRAC_BITS (FRAC_BITS)
    ) u_min (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (min_ctl),
        .d2       (d2_w),
        .best     (best),
        .best_vld (best_vld)
    );

    wnf_pkg::ctl_t sq_ctl;
    logic [OW-1:0] root;
    logic          root_vld;

    assign sq_ctl = '{adv: adv, vld: best_vld};

    wnf_isqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sq_ctl),
        .best     (best),
        .root     (root),
        .root_vld (root_vld)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= root_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv && root_vld)
            out_dist_reg <= root;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24-OW){1'b0}}, out_dist_reg};

    `WNF_ASSERT_IMP(a_ready_when_empty, !out_valid_reg, s_tready,
        "input stalled with empty output register")
    `WNF_ASSERT_NXT(a_result_lands, adv && root_vld, out_valid_reg,
        "finished root did not reach the output register")
endmodule
`default_nettype wire
